// ===== hw/rtl/sarl_pkg.sv =====
`default_nettype none
package sarl_pkg;

	localparam int TABLE_DEPTH = 16384;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ADDR_W      = 32;
	localparam int OUT_IDX_W   = 14;
	localparam int STATUS_W    = 2;

	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [OUT_IDX_W-1:0] out_idx_t;
	typedef logic [STATUS_W-1:0]  status_t;

	localparam status_t ST_LOADED  = 2'd0;
	localparam status_t ST_FULL    = 2'd1;
	localparam status_t ST_MATCH   = 2'd2;
	localparam status_t ST_NOMATCH = 2'd3;

	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic lookup;
		logic step;
		logic emit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic empty;
		logic search_done;
	} stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sarl_ram.sv =====
`default_nettype none
module sarl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16384
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sarl_dp.sv =====
`default_nettype none
module sarl_dp (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sarl_pkg::cmd_t   cmd,
	output sarl_pkg::stat_t       stat,
	input  wire sarl_pkg::addr_t  address,
	output sarl_pkg::status_t     status,
	output sarl_pkg::out_idx_t    entry_index
);

	sarl_pkg::cnt_t     count_q;
	sarl_pkg::cnt_t     lo_q;
	sarl_pkg::cnt_t     hi_q;
	sarl_pkg::cnt_t     mid_q;
	sarl_pkg::addr_t    query_q;
	sarl_pkg::status_t  res_status_q;
	sarl_pkg::out_idx_t res_index_q;
	sarl_pkg::status_t  status_q;
	sarl_pkg::out_idx_t index_q;

	sarl_pkg::addr_t rdata;
	sarl_pkg::idx_t  raddr;
	logic            full;
	logic            le;
	sarl_pkg::cnt_t  lo_n;
	sarl_pkg::cnt_t  hi_n;
	logic [sarl_pkg::CNT_W:0] sum_n;
	sarl_pkg::cnt_t  mid_n;
	sarl_pkg::cnt_t  mid0;

	assign full  = (count_q == sarl_pkg::cnt_t'(sarl_pkg::TABLE_DEPTH));
	assign le    = (rdata <= query_q);
	assign lo_n  = le ? (mid_q + sarl_pkg::cnt_t'(1)) : lo_q;
	assign hi_n  = le ? hi_q : mid_q;
	assign sum_n = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n = sum_n[sarl_pkg::CNT_W:1];
	assign mid0  = count_q >> 1;
	assign raddr = cmd.lookup ? mid0[sarl_pkg::IDX_W-1:0] : mid_n[sarl_pkg::IDX_W-1:0];

	assign stat.empty       = (count_q == '0);
	assign stat.search_done = (lo_n >= hi_n);

	sarl_ram #(
		.WIDTH (sarl_pkg::ADDR_W),
		.DEPTH (sarl_pkg::TABLE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.load && !full),
		.waddr (count_q[sarl_pkg::IDX_W-1:0]),
		.wdata (address),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.load && !full) begin
			count_q <= count_q + sarl_pkg::cnt_t'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (full) begin
				res_status_q <= sarl_pkg::ST_FULL;
				res_index_q  <= '0;
			end else begin
				res_status_q <= sarl_pkg::ST_LOADED;
				res_index_q  <= sarl_pkg::out_idx_t'(count_q);
			end
		end
		if (cmd.lookup) begin
			query_q      <= address;
			lo_q         <= '0;
			hi_q         <= count_q;
			mid_q        <= mid0;
			res_status_q <= sarl_pkg::ST_NOMATCH;
			res_index_q  <= '0;
		end
		if (cmd.step) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
			if (lo_n == '0) begin
				res_status_q <= sarl_pkg::ST_NOMATCH;
				res_index_q  <= '0;
			end else begin
				res_status_q <= sarl_pkg::ST_MATCH;
				res_index_q  <= sarl_pkg::out_idx_t'(lo_n - sarl_pkg::cnt_t'(1));
			end
		end
		if (cmd.emit) begin
			status_q <= res_status_q;
			index_q  <= res_index_q;
		end
	end

	assign status      = status_q;
	assign entry_index = index_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sarl_ctrl.sv =====
`default_nettype none
module sarl_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            func,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output sarl_pkg::cmd_t       cmd,
	input  wire sarl_pkg::stat_t stat
);

	typedef enum logic [1:0] {
		IDLE,
		SEARCH,
		FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready = (state_q == IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		cmd.load   = accept && (func == sarl_pkg::FUNC_LOAD);
		cmd.lookup = accept && (func == sarl_pkg::FUNC_LOOKUP);
		cmd.step   = (state_q == SEARCH);
		cmd.emit   = (state_q == FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (cmd.load) begin
						state_q <= FINISH;
					end else if (cmd.lookup) begin
						state_q <= stat.empty ? FINISH : SEARCH;
					end
				end
				SEARCH: begin
					if (stat.search_done) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (out_free) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sorted_address_range_lookup.sv =====
// Sorted address range lookup: floor search in a table of start addresses.
// Input channel (in_valid/in_ready): func selects the request kind. A load
// request (func 0) appends address as the next entry; once the table holds
// TABLE_DEPTH entries a load is dropped with status "full". A lookup request
// (func 1) binary-searches for the last entry whose start is at or below
// address and returns its index, or "no match" for an empty table or an
// address below the first entry. Entries must be loaded in ascending order.
// Output channel (out_valid/out_ready): status and entry_index, one result
// per request, held in an output register.
// Sequencing: one request at a time. A load or a lookup on an empty table
// goes from accept straight to the finish state, which registers the
// result. A lookup over n entries probes the table RAM (separate read and
// write ports) once per search step, ceil(log2(n+1)) or fewer probes (at
// most 15 for 16384 entries), then the finish state registers the result.
// in_ready rises again in the cycle after the result is registered.
// A finished result waits in the output register while the next request is
// accepted; if the receiver still stalls when that request finishes, the
// block holds it and takes no further request until the output drains.
// Reset empties the table (entry count to zero) and clears out_valid.
`default_nettype none
module sorted_address_range_lookup (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire sarl_pkg::addr_t    address,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output sarl_pkg::status_t       status,
	output sarl_pkg::out_idx_t      entry_index
);

	sarl_pkg::cmd_t  cmd;
	sarl_pkg::stat_t stat;

	sarl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	sarl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.address     (address),
		.status      (status),
		.entry_index (entry_index)
	);

endmodule
`default_nettype wire
